### hw/rtl/faa_pkg.sv
package faa_pkg;

	// Widths fixed by the pixel format and the register map.
	localparam int CH_W      = 8;
	localparam int SUM_W     = 16;
	localparam int DIV_W     = 9;
	localparam int PC_W      = 17;
	localparam int OP_W      = 2;
	localparam int CFG_IDX_W = 2;
	localparam int STEP_W    = 4;

	// Item operations.
	localparam logic [OP_W-1:0] OP_ACC   = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd1;

	// Reset values of the configuration registers.
	localparam logic [PC_W-1:0]  PIXEL_COUNT_RST = 17'h10000;
	localparam logic [DIV_W-1:0] FRAME_COUNT_RST = 9'd1;

	// Three channel sums of one pixel, as stored in the sum memory.
	typedef struct packed {
		logic [SUM_W-1:0] red;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] blue;
	} rgb_sum_t;

	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic done;
	} div_stat_t;

endpackage

### hw/rtl/frame_average_accumulator_unit.sv
// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+----------------------------------------
// input     | in        | in_valid / in_stall   | operation, red_in, green_in, blue_in
// output    | out       | out_valid / out_stall | red_avg, green_avg, blue_avg, frame_done
// config    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// An accumulate item is one memory read, then one write of the updated sums.
// A readout item reads the sums, runs SUM_W = 16 divider steps and then loads its result
// into the output register. The result then sits there and the block takes new items;
// a later result that finds the output register still full waits, with in_stall high.
// A clear item, and reset, start a clearing pass through all MAX_PIXELS entries of the sum
// memory, one entry a cycle; no item is taken meanwhile, configuration writes are.
// The block takes one item at a time; in_stall is high whenever it is not idle.
module frame_average_accumulator_unit #(
	parameter int MAX_PIXELS = 65536
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [faa_pkg::OP_W-1:0]          operation,
	input  logic [faa_pkg::CH_W-1:0]          red_in,
	input  logic [faa_pkg::CH_W-1:0]          green_in,
	input  logic [faa_pkg::CH_W-1:0]          blue_in,

	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [faa_pkg::CH_W-1:0]          red_avg,
	output logic [faa_pkg::CH_W-1:0]          green_avg,
	output logic [faa_pkg::CH_W-1:0]          blue_avg,
	output logic                              frame_done,

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [faa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [faa_pkg::PC_W-1:0]          cfg_data
);

	localparam int AW = $clog2(MAX_PIXELS);
	// Width that holds both the pixel_count register and MAX_PIXELS.
	localparam int CW = (AW + 1 > faa_pkg::PC_W) ? AW + 1 : faa_pkg::PC_W;
	localparam int CH = faa_pkg::CH_W;
	localparam int SW = faa_pkg::SUM_W;

	localparam logic [2:0] ST_SWEEP = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]                   state_q;
	logic [AW-1:0]                sweep_q;
	logic [AW-1:0]                pos_q;
	logic [AW-1:0]                addr_q;
	logic                         last_q;
	logic [faa_pkg::OP_W-1:0]     op_q;
	logic [CH-1:0]                red_q;
	logic [CH-1:0]                green_q;
	logic [CH-1:0]                blue_q;
	logic [faa_pkg::PC_W-1:0]     pixel_count_q;
	logic [faa_pkg::DIV_W-1:0]    frame_count_q;
	logic                         out_valid_q;
	logic [CH-1:0]                red_avg_q;
	logic [CH-1:0]                green_avg_q;
	logic [CH-1:0]                blue_avg_q;
	logic                         frame_done_q;

	logic [CW-1:0]                pc_ext;
	logic [CW-1:0]                eff_ext;
	logic [AW:0]                  eff_count;
	logic [AW-1:0]                pos_use;
	logic [AW:0]                  pos_inc;
	logic                         pos_last;
	logic                         in_xfer;
	logic                         res_load;
	logic [faa_pkg::DIV_W-1:0]    divisor;

	logic                         mem_we;
	logic [AW-1:0]                mem_waddr;
	faa_pkg::rgb_sum_t            mem_wdata;
	faa_pkg::rgb_sum_t            mem_rdata;
	faa_pkg::rgb_sum_t            acc_sum;

	faa_pkg::div_ctrl_t           div_ctrl;
	faa_pkg::div_stat_t           div_stat;
	faa_pkg::rgb_sum_t            div_quo;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// A finished quotient moves to the output register once that register is empty or
	// its transfer completes in the same cycle. The divider holds the quotient meanwhile.
	assign res_load = ((state_q == ST_DIV && div_stat.done) || state_q == ST_OUT) &&
		(!out_valid_q || !out_stall);

	// A pixel count of zero acts as one; one above the memory depth is clamped to it.
	always_comb begin
		pc_ext = CW'(pixel_count_q);
		if (pc_ext == '0) begin
			eff_ext = CW'(1);
		end else if (pc_ext > CW'(MAX_PIXELS)) begin
			eff_ext = CW'(MAX_PIXELS);
		end else begin
			eff_ext = pc_ext;
		end
		eff_count = eff_ext[AW:0];
	end

	// A position left over from a larger frame size restarts at zero.
	always_comb begin
		pos_use  = ({1'b0, pos_q} >= eff_count) ? '0 : pos_q;
		pos_inc  = {1'b0, pos_use} + (AW + 1)'(1);
		pos_last = (pos_inc >= eff_count);
	end

	assign divisor = (frame_count_q == '0) ? faa_pkg::DIV_W'(1) : frame_count_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= faa_pkg::PIXEL_COUNT_RST;
			frame_count_q <= faa_pkg::FRAME_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				faa_pkg::CFG_PIXEL_COUNT: pixel_count_q <= cfg_data;
				faa_pkg::CFG_FRAME_COUNT: frame_count_q <= cfg_data[faa_pkg::DIV_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer. After reset and after a clear item, the sum memory is swept to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			sweep_q     <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_SWEEP: begin
					if (sweep_q == AW'(MAX_PIXELS - 1)) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						case (operation)
							faa_pkg::OP_ACC, faa_pkg::OP_READ: begin
								pos_q   <= pos_last ? '0 : pos_inc[AW-1:0];
								state_q <= ST_READ;
							end
							faa_pkg::OP_CLEAR: begin
								pos_q   <= '0;
								sweep_q <= '0;
								state_q <= ST_SWEEP;
							end
							faa_pkg::OP_NONE: ;
							default: ;
						endcase
					end
				end
				ST_READ: begin
					// The stored sums are on the read port in this cycle.
					state_q <= (op_q == faa_pkg::OP_READ) ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= res_load ? ST_IDLE : ST_OUT;
					end
				end
				ST_OUT: begin
					// The quotient waits here until the output register frees up.
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item payload captured at the input transfer.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q    <= operation;
			addr_q  <= pos_use;
			last_q  <= pos_last;
			red_q   <= red_in;
			green_q <= green_in;
			blue_q  <= blue_in;
		end
	end

	// Result register; only the low byte of each quotient is kept.
	always_ff @(posedge clk) begin
		if (res_load) begin
			red_avg_q    <= div_quo.red[CH-1:0];
			green_avg_q  <= div_quo.green[CH-1:0];
			blue_avg_q   <= div_quo.blue[CH-1:0];
			frame_done_q <= last_q;
		end
	end

	// Sums wrap modulo 2^SUM_W.
	always_comb begin
		acc_sum.red   = mem_rdata.red   + {{(SW - CH){1'b0}}, red_q};
		acc_sum.green = mem_rdata.green + {{(SW - CH){1'b0}}, green_q};
		acc_sum.blue  = mem_rdata.blue  + {{(SW - CH){1'b0}}, blue_q};
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = acc_sum;
		if (state_q == ST_SWEEP) begin
			mem_we    = 1'b1;
			mem_waddr = sweep_q;
			mem_wdata = '0;
		end else if (state_q == ST_READ && op_q == faa_pkg::OP_ACC) begin
			mem_we = 1'b1;
		end
	end

	assign div_ctrl.start = (state_q == ST_READ) && (op_q == faa_pkg::OP_READ);

	faa_sum_mem #(
		.DEPTH (MAX_PIXELS),
		.AW    (AW)
	) u_sum_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (pos_use),
		.rdata (mem_rdata)
	);

	faa_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (mem_rdata),
		.divisor  (divisor),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	assign out_valid  = out_valid_q;
	assign red_avg    = red_avg_q;
	assign green_avg  = green_avg_q;
	assign blue_avg   = blue_avg_q;
	assign frame_done = frame_done_q;

endmodule

### hw/rtl/faa_sum_mem.sv
// Per-pixel sum storage: one write port, one read port, registered read data.
module faa_sum_mem #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  faa_pkg::rgb_sum_t    wdata,
	input  logic [AW-1:0]        raddr,
	output faa_pkg::rgb_sum_t    rdata
);

	faa_pkg::rgb_sum_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/faa_divider.sv
// Restoring radix-2 divider, three channel lanes stepped together, one
// quotient bit per cycle of each SUM_W-bit quotient.
module faa_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  faa_pkg::div_ctrl_t         ctrl,
	input  faa_pkg::rgb_sum_t          dividend,
	input  logic [faa_pkg::DIV_W-1:0]  divisor,
	output faa_pkg::div_stat_t         stat,
	output faa_pkg::rgb_sum_t          quotient
);

	localparam int SW = faa_pkg::SUM_W;
	localparam int DW = faa_pkg::DIV_W;

	logic [SW-1:0]               quo_q  [3];
	logic [DW-1:0]               rem_q  [3];
	logic [DW-1:0]               div_q;
	logic [faa_pkg::STEP_W-1:0]  step_q;
	logic                        busy_q;
	logic                        done_q;

	logic [DW:0]   trial   [3];
	logic          fits    [3];
	logic [DW:0]   diff    [3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			trial[l] = {rem_q[l], quo_q[l][SW-1]};
			fits[l]  = (trial[l] >= {1'b0, div_q});
			diff[l]  = trial[l] - {1'b0, div_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			// The done pulse follows the last quotient step.
			done_q <= !ctrl.start && busy_q && (step_q == faa_pkg::STEP_W'(SW - 1));
			if (ctrl.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == faa_pkg::STEP_W'(SW - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			quo_q[0] <= dividend.red;
			quo_q[1] <= dividend.green;
			quo_q[2] <= dividend.blue;
			for (int l = 0; l < 3; l++) begin
				rem_q[l] <= '0;
			end
			div_q <= divisor;
		end else if (busy_q) begin
			for (int l = 0; l < 3; l++) begin
				// The remainder stays below the divisor, so DW bits hold it.
				rem_q[l] <= fits[l] ? diff[l][DW-1:0] : trial[l][DW-1:0];
				quo_q[l] <= {quo_q[l][SW-2:0], fits[l]};
			end
		end
	end

	assign stat.done      = done_q;
	assign quotient.red   = quo_q[0];
	assign quotient.green = quo_q[1];
	assign quotient.blue  = quo_q[2];

endmodule
